>>> rtl/line_intersection_point_defines.svh
// Assertion macros for the intersection point RTL (used by lip_div).
// Needs clk and arst_n in the scope where a macro is used.
`ifndef LINE_INTERSECTION_POINT_DEFINES_SVH
`define LINE_INTERSECTION_POINT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LIP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define LIP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LIP_ASSERT(lbl, prop)
`define LIP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/lip_pkg.sv
// Shared widths, codes and types of the line intersection point block.
// No dependencies.
package lip_pkg;
	localparam int C   = 16;            // coordinate bits
	localparam int DW  = C + 1;         // direction bits
	localparam int XW  = 2 * C + 3;     // cross product bits
	localparam int NW  = DW + XW;       // numerator and quotient bits
	localparam int OW  = 53;            // output coordinate bits
	localparam int IN_W  = 4 * C + 4 * DW;
	localparam int IN_PW = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = 2 * OW;
	localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;
	// field offsets inside the input tdata
	localparam int O_FBX = 0;
	localparam int O_FBY = C;
	localparam int O_FDX = 2 * C;
	localparam int O_FDY = 2 * C + DW;
	localparam int O_SBX = 2 * C + 2 * DW;
	localparam int O_SBY = 3 * C + 2 * DW;
	localparam int O_SDX = 4 * C + 2 * DW;
	localparam int O_SDY = 4 * C + 3 * DW;

	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_CLOSED = 2'd1;

	localparam logic [1:0] REG_FIRST_START  = 2'd0;
	localparam logic [1:0] REG_FIRST_END    = 2'd1;
	localparam logic [1:0] REG_SECOND_START = 2'd2;
	localparam logic [1:0] REG_SECOND_END   = 2'd3;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_OUTSIDE  = 2'd1,
		ST_PARALLEL = 2'd2,
		ST_ZERO     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] first_start;
		logic [1:0] first_end;
		logic [1:0] second_start;
		logic [1:0] second_end;
	} cfg_t;

	typedef struct packed {
		logic signed [C-1:0]  fbx;
		logic signed [C-1:0]  fby;
		logic signed [DW-1:0] fdx;
		logic signed [DW-1:0] fdy;
		logic signed [C-1:0]  sbx;
		logic signed [C-1:0]  sby;
		logic signed [DW-1:0] sdx;
		logic signed [DW-1:0] sdy;
	} line_in_t;

	typedef struct packed {
		status_t              status;
		logic                 ls_neg;
		logic [XW-1:0]        s_mag;
		logic [XW-1:0]        ls_mag;
		logic signed [DW-1:0] dir_x;
		logic signed [DW-1:0] dir_y;
		logic signed [C-1:0]  base_x;
		logic signed [C-1:0]  base_y;
	} cross_out_t;

	typedef struct packed {
		status_t             status;
		logic                neg_x;
		logic                neg_y;
		logic signed [C-1:0] base_x;
		logic signed [C-1:0] base_y;
	} tag_t;

	// mode none passes, closed allows equality, anything else is open
	function automatic logic bound_ok(logic [1:0] mode, logic signed [XW-1:0] a,
		logic signed [XW-1:0] b);
		logic r;
		case (mode)
			MODE_NONE:   r = 1'b1;
			MODE_CLOSED: r = (a <= b);
			default:     r = (a < b);
		endcase
		return r;
	endfunction
endpackage

>>> rtl/lip_cross.sv
// Cross products, sign normalization and bound checks (four stages).
// Depends on lip_pkg.
module lip_cross (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  lip_pkg::line_in_t   in_line,
	input  lip_pkg::cfg_t       cfg,
	output logic                out_valid,
	output lip_pkg::cross_out_t out_data
);
	localparam int C  = lip_pkg::C;
	localparam int DW = lip_pkg::DW;
	localparam int XW = lip_pkg::XW;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic                   zero_s1;
	logic signed [XW-2:0]   pa_s1, pb_s1, pc_s1, pd_s1, pe_s1, pf_s1;
	logic signed [DW-1:0]   dx_dir_s1, dy_dir_s1;
	logic signed [C-1:0]    bx_s1, by_s1;
	logic signed [DW-1:0]   dx;
	logic signed [DW-1:0]   dy;

	logic                   zero_s2;
	logic signed [XW-1:0]   s_s2, ls_s2, rs_s2;
	logic signed [DW-1:0]   dx_dir_s2, dy_dir_s2;
	logic signed [C-1:0]    bx_s2, by_s2;

	logic                   zero_s3, par_s3;
	logic signed [XW-1:0]   s_s3, ls_s3, rs_s3;
	logic signed [DW-1:0]   dx_dir_s3, dy_dir_s3;
	logic signed [C-1:0]    bx_s3, by_s3;

	logic                   inb;
	lip_pkg::cross_out_t    data_s4;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign dx = DW'(in_line.sbx) - DW'(in_line.fbx);
	assign dy = DW'(in_line.sby) - DW'(in_line.fby);

	// stage 1: six products and the zero-length test
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1   <= ((in_line.fdx == '0) && (in_line.fdy == '0)) ||
				((in_line.sdx == '0) && (in_line.sdy == '0));
			pa_s1     <= (XW-1)'(in_line.fdx) * (XW-1)'(in_line.sdy);
			pb_s1     <= (XW-1)'(in_line.fdy) * (XW-1)'(in_line.sdx);
			pc_s1     <= (XW-1)'(dx) * (XW-1)'(in_line.sdy);
			pd_s1     <= (XW-1)'(dy) * (XW-1)'(in_line.sdx);
			pe_s1     <= (XW-1)'(dx) * (XW-1)'(in_line.fdy);
			pf_s1     <= (XW-1)'(dy) * (XW-1)'(in_line.fdx);
			dx_dir_s1 <= in_line.fdx;
			dy_dir_s1 <= in_line.fdy;
			bx_s1     <= in_line.fbx;
			by_s1     <= in_line.fby;
		end
	end

	// stage 2: cross products s, ls, rs
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s2   <= zero_s1;
			s_s2      <= XW'(pa_s1) - XW'(pb_s1);
			ls_s2     <= XW'(pc_s1) - XW'(pd_s1);
			rs_s2     <= XW'(pe_s1) - XW'(pf_s1);
			dx_dir_s2 <= dx_dir_s1;
			dy_dir_s2 <= dy_dir_s1;
			bx_s2     <= bx_s1;
			by_s2     <= by_s1;
		end
	end

	// stage 3: flip all signs when s is negative
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s3   <= zero_s2;
			par_s3    <= (s_s2 == '0);
			s_s3      <= s_s2[XW-1] ? -s_s2 : s_s2;
			ls_s3     <= s_s2[XW-1] ? -ls_s2 : ls_s2;
			rs_s3     <= s_s2[XW-1] ? -rs_s2 : rs_s2;
			dx_dir_s3 <= dx_dir_s2;
			dy_dir_s3 <= dy_dir_s2;
			bx_s3     <= bx_s2;
			by_s3     <= by_s2;
		end
	end

	assign inb = lip_pkg::bound_ok(cfg.first_start, '0, ls_s3) &&
		lip_pkg::bound_ok(cfg.first_end, ls_s3, s_s3) &&
		lip_pkg::bound_ok(cfg.second_start, '0, rs_s3) &&
		lip_pkg::bound_ok(cfg.second_end, rs_s3, s_s3);

	// stage 4: status, magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s3) begin
				data_s4.status <= lip_pkg::ST_ZERO;
			end else if (par_s3) begin
				data_s4.status <= lip_pkg::ST_PARALLEL;
			end else if (inb) begin
				data_s4.status <= lip_pkg::ST_HIT;
			end else begin
				data_s4.status <= lip_pkg::ST_OUTSIDE;
			end
			data_s4.ls_neg <= ls_s3[XW-1];
			data_s4.s_mag  <= s_s3;
			data_s4.ls_mag <= ls_s3[XW-1] ? -ls_s3 : ls_s3;
			data_s4.dir_x  <= dx_dir_s3;
			data_s4.dir_y  <= dy_dir_s3;
			data_s4.base_x <= bx_s3;
			data_s4.base_y <= by_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;
endmodule

>>> rtl/lip_div.sv
// Pipelined restoring divider, one quotient bit per stage, both axes.
// Depends on lip_pkg and line_intersection_point_defines.svh.
`include "line_intersection_point_defines.svh"
module lip_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  logic [lip_pkg::NW-1:0]  num_x,
	input  logic [lip_pkg::NW-1:0]  num_y,
	input  logic [lip_pkg::XW-1:0]  den,
	input  lip_pkg::tag_t           in_tag,
	output logic                    out_valid,
	output logic [lip_pkg::NW-1:0]  q_x,
	output logic [lip_pkg::NW-1:0]  q_y,
	output lip_pkg::tag_t           out_tag
);
	localparam int NW = lip_pkg::NW;
	localparam int XW = lip_pkg::XW;

	logic                vld_s  [NW];
	logic [NW-1:0]       numx_s [NW];
	logic [NW-1:0]       numy_s [NW];
	logic [NW-1:0]       qx_s   [NW];
	logic [NW-1:0]       qy_s   [NW];
	logic [XW-1:0]       remx_s [NW];
	logic [XW-1:0]       remy_s [NW];
	logic [XW-1:0]       den_s  [NW];
	lip_pkg::tag_t       tag_s  [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic          v_in;
		logic [NW-1:0] nx_in, ny_in, qx_in, qy_in;
		logic [XW-1:0] rx_in, ry_in, d_in, tx, ty;
		lip_pkg::tag_t t_in;
		logic          gex, gey;

		if (i == 0) begin : g_first
			assign v_in  = in_valid;
			assign nx_in = num_x;
			assign ny_in = num_y;
			assign qx_in = '0;
			assign qy_in = '0;
			assign rx_in = '0;
			assign ry_in = '0;
			assign d_in  = den;
			assign t_in  = in_tag;
		end else begin : g_next
			assign v_in  = vld_s[i-1];
			assign nx_in = numx_s[i-1];
			assign ny_in = numy_s[i-1];
			assign qx_in = qx_s[i-1];
			assign qy_in = qy_s[i-1];
			assign rx_in = remx_s[i-1];
			assign ry_in = remy_s[i-1];
			assign d_in  = den_s[i-1];
			assign t_in  = tag_s[i-1];
		end

		// bring down the next numerator bit and try the subtract
		assign tx  = {rx_in[XW-2:0], nx_in[NW-1]};
		assign ty  = {ry_in[XW-2:0], ny_in[NW-1]};
		assign gex = (tx >= d_in);
		assign gey = (ty >= d_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				numx_s[i] <= {nx_in[NW-2:0], 1'b0};
				numy_s[i] <= {ny_in[NW-2:0], 1'b0};
				qx_s[i]   <= {qx_in[NW-2:0], gex};
				qy_s[i]   <= {qy_in[NW-2:0], gey};
				remx_s[i] <= gex ? tx - d_in : tx;
				remy_s[i] <= gey ? ty - d_in : ty;
				den_s[i]  <= d_in;
				tag_s[i]  <= t_in;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign q_x       = qx_s[NW-1];
	assign q_y       = qy_s[NW-1];
	assign out_tag   = tag_s[NW-1];

	// a zero divisor only comes with parallel or zero-length items
	`LIP_ASSERT(a_remx_lt_den, (vld_s[NW-1] && den_s[NW-1] != '0) |-> (remx_s[NW-1] < den_s[NW-1]))
	`LIP_ASSERT(a_remy_lt_den, (vld_s[NW-1] && den_s[NW-1] != '0) |-> (remy_s[NW-1] < den_s[NW-1]))
	`LIP_ASSERT_NEXT(a_hold_on_stall, !adv, $stable(qx_s[NW-1]) && $stable(vld_s[NW-1]))
endmodule

>>> rtl/line_intersection_point.sv
// Intersection point of two integer lines, top level.
// Depends on lip_pkg, lip_cross and lip_div.
//
// Input stream s_*: one transaction carries both lines (base points and
// direction vectors). Output stream m_*: one transaction per input, status
// in m_tuser and the crossing point in m_tdata (zero unless status is hit).
// Configuration: cfg_we writes cfg_data into the bound-mode register chosen
// by cfg_index; write it only while the pipeline is empty.
// Pipeline from input transaction to m_tvalid: four cross-product stages,
// one multiply stage, 52 divider stages, one output register.
// Throughput: one transaction per cycle when not stalled; the divider
// retires one quotient bit per stage so an item enters every such cycle.
// Reset clears all valid bits and sets every bound mode to closed.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module line_intersection_point (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// first_base_x, first_base_y, first_dir_x, first_dir_y,
	// second_base_x, second_base_y, second_dir_x, second_dir_y, zero pad
	input  logic [lip_pkg::IN_PW-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// cross_x, cross_y, zero pad
	output logic [lip_pkg::OUT_PW-1:0]  m_tdata,
	// status
	output logic [1:0]                  m_tuser,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [1:0]                  cfg_data
);
	localparam int C  = lip_pkg::C;
	localparam int DW = lip_pkg::DW;
	localparam int XW = lip_pkg::XW;
	localparam int NW = lip_pkg::NW;
	localparam int OW = lip_pkg::OW;

	logic                  adv;
	lip_pkg::cfg_t         cfg_q;
	lip_pkg::line_in_t     in_line;
	logic                  cr_valid;
	lip_pkg::cross_out_t   cr_data;
	logic [DW-1:0]         dmag_x, dmag_y;

	logic                  valid_s5;
	logic [NW-1:0]         numx_s5, numy_s5;
	logic [XW-1:0]         den_s5;
	lip_pkg::tag_t         tag_s5;

	logic                  dv_valid;
	logic [NW-1:0]         dv_qx, dv_qy;
	lip_pkg::tag_t         dv_tag;
	logic signed [OW-1:0]  px, py, qx_w, qy_w;

	logic                  m_tvalid_q;
	logic [OW-1:0]         cx_q, cy_q;
	lip_pkg::status_t      status_q;

	// hold everything while a result waits
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= {4{lip_pkg::MODE_CLOSED}};
		end else if (cfg_we) begin
			case (cfg_index)
				lip_pkg::REG_FIRST_START:  cfg_q.first_start  <= cfg_data;
				lip_pkg::REG_FIRST_END:    cfg_q.first_end    <= cfg_data;
				lip_pkg::REG_SECOND_START: cfg_q.second_start <= cfg_data;
				lip_pkg::REG_SECOND_END:   cfg_q.second_end   <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// unpack input fields
	assign in_line.fbx = s_tdata[lip_pkg::O_FBX +: C];
	assign in_line.fby = s_tdata[lip_pkg::O_FBY +: C];
	assign in_line.fdx = s_tdata[lip_pkg::O_FDX +: DW];
	assign in_line.fdy = s_tdata[lip_pkg::O_FDY +: DW];
	assign in_line.sbx = s_tdata[lip_pkg::O_SBX +: C];
	assign in_line.sby = s_tdata[lip_pkg::O_SBY +: C];
	assign in_line.sdx = s_tdata[lip_pkg::O_SDX +: DW];
	assign in_line.sdy = s_tdata[lip_pkg::O_SDY +: DW];

	lip_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.in_line   (in_line),
		.cfg       (cfg_q),
		.out_valid (cr_valid),
		.out_data  (cr_data)
	);

	assign dmag_x = cr_data.dir_x[DW-1] ? -cr_data.dir_x : cr_data.dir_x;
	assign dmag_y = cr_data.dir_y[DW-1] ? -cr_data.dir_y : cr_data.dir_y;

	// stage 5: numerators |dir| * |ls|
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= cr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			numx_s5       <= NW'(dmag_x) * NW'(cr_data.ls_mag);
			numy_s5       <= NW'(dmag_y) * NW'(cr_data.ls_mag);
			den_s5        <= cr_data.s_mag;
			tag_s5.status <= cr_data.status;
			tag_s5.neg_x  <= cr_data.dir_x[DW-1] ^ cr_data.ls_neg;
			tag_s5.neg_y  <= cr_data.dir_y[DW-1] ^ cr_data.ls_neg;
			tag_s5.base_x <= cr_data.base_x;
			tag_s5.base_y <= cr_data.base_y;
		end
	end

	lip_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (valid_s5),
		.num_x     (numx_s5),
		.num_y     (numy_s5),
		.den       (den_s5),
		.in_tag    (tag_s5),
		.out_valid (dv_valid),
		.q_x       (dv_qx),
		.q_y       (dv_qy),
		.out_tag   (dv_tag)
	);

	// apply sign and add base point
	assign qx_w = OW'(dv_qx);
	assign qy_w = OW'(dv_qy);
	assign px   = dv_tag.neg_x ? OW'(dv_tag.base_x) - qx_w : OW'(dv_tag.base_x) + qx_w;
	assign py   = dv_tag.neg_y ? OW'(dv_tag.base_y) - qy_w : OW'(dv_tag.base_y) + qy_w;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= dv_tag.status;
			cx_q     <= (dv_tag.status == lip_pkg::ST_HIT) ? px : '0;
			cy_q     <= (dv_tag.status == lip_pkg::ST_HIT) ? py : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {{(lip_pkg::OUT_PW - lip_pkg::OUT_W){1'b0}}, cy_q, cx_q};
endmodule
